// ===== src/mccr_pkg.sv =====
// ---------------------------------------------------------------------------
// mccr_pkg: shared types and constants for the cubic curve rasterizer
// Fixed field widths, request, status and register codes, decision variable
// constants, the widths of the shared multiplier and the vertical axis bound.
// ---------------------------------------------------------------------------
package mccr_pkg;

	// Fixed field widths
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 3;
	localparam int SCALE_W = 9;
	localparam int STEP_W  = 10;
	localparam int DEC_W   = 20;
	localparam int LIM_W   = 20;
	localparam int ADDR_W  = 1;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 27;
	localparam int MUL_B_W = 11;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_PIXEL    = 3'd0;
	localparam logic [STAT_W-1:0] ST_STARTED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_DONE     = 3'd2;
	localparam logic [STAT_W-1:0] ST_BADSCALE = 3'd3;
	localparam logic [STAT_W-1:0] ST_BUSY     = 3'd4;
	localparam logic [STAT_W-1:0] ST_IDLE     = 3'd5;

	// Register indexes
	localparam logic [ADDR_W-1:0] REG_SCALE = 1'd0;
	localparam logic [ADDR_W-1:0] REG_AXIS  = 1'd1;

	// Decision variable constants
	localparam logic [DEC_W-1:0] DEC_START  = 20'hFFFFB;   // -5
	localparam logic [DEC_W-1:0] R1_POS_ADJ = 20'hFFFFB;   // -5
	localparam logic [DEC_W-1:0] R1_NEG_ADJ = 20'd7;
	localparam logic [DEC_W-1:0] R2_STEP    = 20'd96;
	localparam logic [DEC_W-1:0] R2_POS_ADJ = R2_STEP - 20'd26;

	// Vertical axis bound multiplier
	localparam logic [MUL_B_W-1:0] AXY_MUL = 11'd100;

endpackage

// ===== src/midpoint_cubic_curve_raster.sv =====
// ---------------------------------------------------------------------------
// midpoint_cubic_curve_raster: midpoint rasterizer for y = x^3/12
// Draws the curve point-symmetric about a latched origin, then optional
// axis pixels, one step per tick request.
// ---------------------------------------------------------------------------
// Usage:
//   Request beats enter on the s_ channel (s_tuser is the request type,
//   s_tdata the origin). Result beats leave on the m_ channel; m_tlast marks
//   the final beat caused by a request. Registers are written on cfg_we.
//   A start, clear or idle tick gives one status beat from the state
//   S_SINGLE, and a drawing tick gives two pixel beats from S_PAIR0 and
//   S_PAIR1 before S_UPD advances the step. A tick that crosses into region
//   two first makes two passes through the shared multiplier for the cube,
//   one that enters the horizontal axis evaluates again, and one that enters
//   the vertical axis makes three passes for 100*scale^3. s_tready is high
//   only while the sequencer waits for a request; the last result beat may
//   still sit in the output register while the next request is taken.
//   Reset returns to the ready phase with registers cleared. A stall on
//   m_tready holds the current result beat and the sequencer behind it.
// ---------------------------------------------------------------------------
module midpoint_cubic_curve_raster #(
	parameter int COORD_WIDTH = 12,
	parameter int SCALE_FRAC  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port
	input  logic                                 cfg_we,
	input  logic [mccr_pkg::ADDR_W-1:0]          cfg_addr,
	input  logic [mccr_pkg::SCALE_W-1:0]         cfg_wdata,
	// Request channel
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata: origin_x, origin_y
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	// s_tuser: req_type
	input  logic [mccr_pkg::REQ_W-1:0]           s_tuser,
	// Result channel
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata: pixel_x, pixel_y, pixel_color
	output logic [((2*COORD_WIDTH+12)/8)*8-1:0]  m_tdata,
	// m_tuser: status
	output logic [mccr_pkg::STAT_W-1:0]          m_tuser,
	output logic                                 m_tlast
);

	localparam int PW = COORD_WIDTH + 2;
	localparam int MW = ((2*COORD_WIDTH+12)/8)*8;
	localparam int unsigned ONE = 1 << SCALE_FRAC;

	typedef enum logic [2:0] {
		PH_READY = 3'd0,
		PH_R1    = 3'd1,
		PH_R2    = 3'd2,
		PH_AXX   = 3'd3,
		PH_AXY   = 3'd4,
		PH_DRAWN = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EVAL, S_CUBE0, S_CUBE1, S_CUBE2,
		S_AXY0, S_AXY1, S_AXY2, S_AXY3,
		S_PAIR0, S_PAIR1, S_UPD, S_SINGLE
	} seq_t;

	seq_t                           state_q;
	phase_t                         phase_q;
	logic [mccr_pkg::STEP_W-1:0]    step_x_q, step_y_q, ex_q, ey_q;
	logic [mccr_pkg::DEC_W-1:0]     dec_q;
	logic [COORD_WIDTH-1:0]         cx_q, cy_q;
	logic [mccr_pkg::LIM_W-1:0]     lim_q;
	logic [mccr_pkg::SCALE_W-1:0]   scale_q;
	logic                           axis_en_q;
	logic [mccr_pkg::STAT_W-1:0]    stat_q;
	logic                           col_q;

	logic                           m_tvalid_q;
	logic signed [PW-1:0]           px_q, py_q;
	logic                           pc_q, last_q;
	logic [mccr_pkg::STAT_W-1:0]    st_q;

	logic                           mul_en;
	logic [mccr_pkg::MUL_A_W-1:0]   mul_a;
	logic [mccr_pkg::MUL_B_W-1:0]   mul_b;
	logic [mccr_pkg::MUL_P_W-1:0]   prod;
	logic [mccr_pkg::MUL_P_W-1:0]   prod_sh;

	logic [31:0]                    wide_x, bnd2, bnd10, axx_full;
	logic                           in_r1, in_r2, in_ax, bad_scale, dec_pos, out_free;
	logic                           out_load;
	logic [mccr_pkg::DEC_W-1:0]     xx, x20, y1, r1_new, r2_new, cube_dec;
	logic [mccr_pkg::MUL_B_W-1:0]   odd_x;

	// Shared multiplier
	mccr_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Bound tests and scale check
	always_comb begin
		wide_x    = 32'(step_x_q) << SCALE_FRAC;
		bnd2      = 32'(scale_q) << 1;
		bnd10     = (32'(scale_q) << 3) + (32'(scale_q) << 1);
		in_r1     = wide_x <= bnd2;
		in_r2     = wide_x <= bnd10;
		in_ax     = mccr_pkg::LIM_W'(step_x_q) <= lim_q;
		axx_full  = ((32'(scale_q) << 6) - (32'(scale_q) << 2)) >> SCALE_FRAC;
		prod_sh   = prod >> (3*SCALE_FRAC);
		bad_scale = (32'(scale_q) < 32'(ONE)) || ((32'(scale_q) << 1) > 32'(3*ONE));
	end

	// Decision variable updates
	always_comb begin
		xx       = prod[mccr_pkg::DEC_W-1:0];
		x20      = mccr_pkg::DEC_W'(step_x_q);
		y1       = mccr_pkg::DEC_W'(step_y_q) + mccr_pkg::DEC_W'(1);
		dec_pos  = !dec_q[mccr_pkg::DEC_W-1] && (dec_q != '0);
		r1_new   = dec_q + xx + (xx << 1) + x20 + (x20 << 3)
		         + (dec_pos ? mccr_pkg::R1_POS_ADJ : mccr_pkg::R1_NEG_ADJ);
		r2_new   = dec_pos ?
		           dec_q + mccr_pkg::R2_POS_ADJ - ((xx << 4) + (xx << 3))
		           - ((x20 << 5) + (x20 << 4)) :
		           dec_q + mccr_pkg::R2_STEP;
		cube_dec = (y1 << 6) + (y1 << 5) - prod[mccr_pkg::DEC_W-1:0];
		odd_x    = {step_x_q, 1'b1};
	end

	// Issue operands to the shared multiplier
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_EVAL: begin
				mul_en = 1'b1;
				mul_a  = mccr_pkg::MUL_A_W'(step_x_q);
				mul_b  = mccr_pkg::MUL_B_W'(step_x_q);
			end
			S_CUBE0: begin
				mul_en = 1'b1;
				mul_a  = mccr_pkg::MUL_A_W'(odd_x);
				mul_b  = odd_x;
			end
			S_CUBE1: begin
				mul_en = 1'b1;
				mul_a  = mccr_pkg::MUL_A_W'(prod[21:0]);
				mul_b  = odd_x;
			end
			S_AXY0: begin
				mul_en = 1'b1;
				mul_a  = mccr_pkg::MUL_A_W'(scale_q);
				mul_b  = mccr_pkg::MUL_B_W'(scale_q);
			end
			S_AXY1: begin
				mul_en = 1'b1;
				mul_a  = prod[mccr_pkg::MUL_A_W-1:0];
				mul_b  = mccr_pkg::MUL_B_W'(scale_q);
			end
			S_AXY2: begin
				mul_en = 1'b1;
				mul_a  = prod[mccr_pkg::MUL_A_W-1:0];
				mul_b  = mccr_pkg::AXY_MUL;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free &&
	                  (state_q == S_PAIR0 || state_q == S_PAIR1 || state_q == S_SINGLE);

	// Sequencer, drawing state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_READY;
			step_x_q   <= '0;
			step_y_q   <= '0;
			dec_q      <= '0;
			cx_q       <= '0;
			cy_q       <= '0;
			lim_q      <= '0;
			scale_q    <= '0;
			axis_en_q  <= 1'b0;
			stat_q     <= mccr_pkg::ST_IDLE;
			ex_q       <= '0;
			ey_q       <= '0;
			col_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			px_q       <= '0;
			py_q       <= '0;
			pc_q       <= 1'b0;
			st_q       <= mccr_pkg::ST_IDLE;
			last_q     <= 1'b0;
		end else begin
			// Register writes
			if (cfg_we) begin
				unique case (cfg_addr)
					mccr_pkg::REG_SCALE: scale_q   <= cfg_wdata;
					mccr_pkg::REG_AXIS:  axis_en_q <= cfg_wdata[0];
					default:             scale_q   <= scale_q;
				endcase
			end

			// Drop the output beat once taken, unless a new one replaces it
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							mccr_pkg::REQ_START: begin
								state_q <= S_SINGLE;
								if (phase_q != PH_READY) begin
									stat_q <= mccr_pkg::ST_BUSY;
								end else if (bad_scale) begin
									stat_q  <= mccr_pkg::ST_BADSCALE;
									phase_q <= PH_DRAWN;
								end else begin
									stat_q   <= mccr_pkg::ST_STARTED;
									phase_q  <= PH_R1;
									cx_q     <= s_tdata[COORD_WIDTH-1:0];
									cy_q     <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
									step_x_q <= '0;
									step_y_q <= '0;
									dec_q    <= mccr_pkg::DEC_START;
									lim_q    <= '0;
								end
							end
							mccr_pkg::REQ_TICK: begin
								state_q <= S_EVAL;
							end
							mccr_pkg::REQ_CLEAR: begin
								state_q  <= S_SINGLE;
								stat_q   <= mccr_pkg::ST_IDLE;
								phase_q  <= PH_READY;
								step_x_q <= '0;
								step_y_q <= '0;
								dec_q    <= '0;
								cx_q     <= '0;
								cy_q     <= '0;
								lim_q    <= '0;
							end
							default: begin
								state_q <= S_SINGLE;
								stat_q  <= mccr_pkg::ST_IDLE;
							end
						endcase
					end
				end
				S_EVAL: begin
					unique case (phase_q)
						PH_R1: begin
							if (in_r1) begin
								ex_q    <= step_x_q;
								ey_q    <= step_y_q;
								col_q   <= 1'b0;
								state_q <= S_PAIR0;
							end else begin
								state_q <= S_CUBE0;
							end
						end
						PH_R2: begin
							if (in_r2) begin
								ex_q    <= step_x_q;
								ey_q    <= step_y_q;
								col_q   <= 1'b0;
								state_q <= S_PAIR0;
							end else if (axis_en_q) begin
								phase_q  <= PH_AXX;
								step_x_q <= '0;
								lim_q    <= axx_full[mccr_pkg::LIM_W-1:0];
							end else begin
								phase_q <= PH_DRAWN;
								stat_q  <= mccr_pkg::ST_DONE;
								state_q <= S_SINGLE;
							end
						end
						PH_AXX: begin
							if (in_ax) begin
								ex_q    <= step_x_q;
								ey_q    <= '0;
								col_q   <= 1'b1;
								state_q <= S_PAIR0;
							end else begin
								state_q <= S_AXY0;
							end
						end
						PH_AXY: begin
							if (in_ax) begin
								ex_q    <= '0;
								ey_q    <= step_x_q;
								col_q   <= 1'b1;
								state_q <= S_PAIR0;
							end else begin
								phase_q <= PH_DRAWN;
								stat_q  <= mccr_pkg::ST_DONE;
								state_q <= S_SINGLE;
							end
						end
						default: begin
							stat_q  <= mccr_pkg::ST_IDLE;
							state_q <= S_SINGLE;
						end
					endcase
				end
				// Cube of 2x+1 for the region two decision value
				S_CUBE0: state_q <= S_CUBE1;
				S_CUBE1: state_q <= S_CUBE2;
				S_CUBE2: begin
					dec_q   <= cube_dec;
					phase_q <= PH_R2;
					state_q <= S_EVAL;
				end
				// 100*scale^3 for the vertical axis bound
				S_AXY0: state_q <= S_AXY1;
				S_AXY1: state_q <= S_AXY2;
				S_AXY2: state_q <= S_AXY3;
				S_AXY3: begin
					phase_q  <= PH_AXY;
					step_x_q <= '0;
					lim_q    <= prod_sh[mccr_pkg::LIM_W-1:0];
					state_q  <= S_EVAL;
				end
				S_PAIR0: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						px_q       <= PW'(cx_q) - PW'(ex_q);
						py_q       <= PW'(cy_q) + PW'(ey_q);
						pc_q       <= col_q;
						st_q       <= mccr_pkg::ST_PIXEL;
						last_q     <= 1'b0;
						state_q    <= S_PAIR1;
					end
				end
				S_PAIR1: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						px_q       <= PW'(cx_q) + PW'(ex_q);
						py_q       <= PW'(cy_q) - PW'(ey_q);
						pc_q       <= col_q;
						st_q       <= mccr_pkg::ST_PIXEL;
						last_q     <= 1'b1;
						state_q    <= S_UPD;
					end
				end
				// Advance the step counters and decision variable
				S_UPD: begin
					unique case (phase_q)
						PH_R1: begin
							dec_q    <= r1_new;
							step_x_q <= step_x_q + 1'b1;
							if (dec_pos) begin
								step_y_q <= step_y_q + 1'b1;
							end
						end
						PH_R2: begin
							dec_q    <= r2_new;
							step_y_q <= step_y_q + 1'b1;
							if (dec_pos) begin
								step_x_q <= step_x_q + 1'b1;
							end
						end
						PH_AXX, PH_AXY: begin
							step_x_q <= step_x_q + 1'b1;
						end
						default: begin
							step_x_q <= step_x_q;
						end
					endcase
					state_q <= S_IDLE;
				end
				S_SINGLE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						px_q       <= '0;
						py_q       <= '0;
						pc_q       <= 1'b0;
						st_q       <= stat_q;
						last_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = MW'({pc_q, py_q, px_q});
	assign m_tuser  = st_q;
	assign m_tlast  = last_q;

endmodule

// ===== src/mccr_mul.sv =====
// ---------------------------------------------------------------------------
// mccr_mul: shared multiplier
// One unsigned product per issue, registered; holds its value until the
// next issue.
// ---------------------------------------------------------------------------
module mccr_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [mccr_pkg::MUL_A_W-1:0]  a,
	input  logic [mccr_pkg::MUL_B_W-1:0]  b,
	output logic [mccr_pkg::MUL_P_W-1:0]  p
);

	// Capture the product on issue
	always_ff @(posedge clk) begin
		if (en) begin
			p <= mccr_pkg::MUL_P_W'(a) * mccr_pkg::MUL_P_W'(b);
		end
	end

endmodule
